FILE: hdl/eesp_pkg.sv
// eesp_pkg: shared types, codes and helper function of the element stream parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package eesp_pkg;

  // stream actions
  typedef enum logic [2:0] {
    ACT_BYTE     = 3'd0,
    ACT_ENTER    = 3'd1,
    ACT_SKIP     = 3'd2,
    ACT_READ_U   = 3'd3,
    ACT_READ_S   = 3'd4,
    ACT_READ_RAW = 3'd5,
    ACT_END      = 3'd6,
    ACT_SET_POS  = 3'd7
  } action_t;

  // result kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_BYTE   = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_ID_TAG    = 3'd1;
  localparam logic [2:0] ERR_LEN_TAG   = 3'd2;
  localparam logic [2:0] ERR_INT_SIZE  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

  // configuration register indexes
  localparam logic CFG_VOID_ID = 1'b0;
  localparam logic CFG_CRC_ID  = 1'b1;

  localparam logic [31:0] VOID_ID_RESET = 32'd236;
  localparam logic [31:0] CRC_ID_RESET  = 32'd191;

  localparam logic [3:0] CLOSED_SAT = 4'd14;
  localparam logic [3:0] CLOSED_END = 4'd15;

  typedef struct packed {
    action_t     action;
    logic [7:0]  data_byte;
    logic [63:0] new_position;
  } item_t;

  // classification done by the front end
  typedef struct packed {
    logic is_byte;
    logic is_cmd;
    logic is_end;
    logic is_set_pos;
  } class_t;

  typedef struct packed {
    item_t  item;
    class_t cls;
  } qent_t;

  typedef struct packed {
    logic [1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic [3:0] depth;
  } back_stat_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        element_id;
    logic [63:0]        data_length;
    logic               length_unknown;
    logic [3:0]         levels_closed;
    logic signed [63:0] int_value;
    logic [7:0]         payload_byte;
    logic               last_byte;
    logic [2:0]         error_code;
  } result_t;

  // size of a vint from its first byte, 9 when no marker bit is set
  // the highest set bit decides, so it is scanned last
  function automatic logic [3:0] lead_size(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/eesp_front.sv
// eesp_front: accepts items, classifies the action and queues them for the back end
// depends on eesp_pkg
`timescale 1ns / 1ps
`default_nettype none
module eesp_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire eesp_pkg::item_t      in_item,
  output logic                      q_valid,
  output eesp_pkg::qent_t           q_head,
  input  wire logic                 q_pop,
  output eesp_pkg::front_stat_t     stat
);
  import eesp_pkg::*;

  qent_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  qent_t      ent;

  // classify the incoming action
  always_comb begin
    ent.item           = in_item;
    ent.cls.is_byte    = (in_item.action == ACT_BYTE);
    ent.cls.is_end     = (in_item.action == ACT_END);
    ent.cls.is_set_pos = (in_item.action == ACT_SET_POS);
    ent.cls.is_cmd     = !ent.cls.is_byte && !ent.cls.is_end && !ent.cls.is_set_pos;
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign q_valid    = (count != 2'd0);
  assign q_head     = slots[rptr];
  assign stat.count = count;

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= ent;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (q_pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/eesp_back.sv
// eesp_back: decodes ids and lengths, tracks nesting, runs commands, holds the result register
// depends on eesp_pkg
`timescale 1ns / 1ps
`default_nettype none
module eesp_back #(
  parameter int MAX_NESTING = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire eesp_pkg::qent_t      q_head,
  output logic                      q_pop,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output eesp_pkg::result_t         out_res,
  output eesp_pkg::back_stat_t      stat
);
  import eesp_pkg::*;

  localparam int IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam logic [3:0] MAX_D = 4'(MAX_NESTING);

  typedef enum logic [6:0] {
    PH_ID   = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_CMD  = 7'b0000100,
    PH_SKIP = 7'b0001000,
    PH_INT  = 7'b0010000,
    PH_RAW  = 7'b0100000,
    PH_ERR  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] position, position_next;
  logic [31:0] id_acc, id_acc_next;
  logic [63:0] len_acc, len_acc_next;
  logic [3:0]  fbl, fbl_next;
  logic [3:0]  ones, ones_next;
  logic [3:0]  len_size, len_size_next;
  logic        len_unk, len_unk_next;
  logic [63:0] payload_left, payload_left_next;
  logic        rd_signed, rd_signed_next;
  logic [63:0] val_acc, val_acc_next;
  logic [3:0]  pending, pending_next;
  logic [3:0]  depth, depth_next;
  logic [63:0] level_ends [MAX_NESTING];
  logic [31:0] void_id;
  logic [31:0] crc_id;

  logic        go;
  logic        has_res;
  result_t     res;
  logic        push_end;
  logic [63:0] push_val;
  logic [3:0]  dm1;
  logic        pop_hit;
  logic [7:0]  b;
  logic [3:0]  n;
  logic [7:0]  mask;
  logic        done;
  logic [63:0] len_new;
  logic [3:0]  ones_new;
  logic [3:0]  size_new;
  logic        unk_new;
  logic [64:0] end_sum;
  logic [63:0] pl_dec;
  logic [63:0] v;

  assign stat.depth = depth;
  assign dm1        = depth - 4'd1;
  assign pop_hit    = (depth != 4'd0) && (position >= level_ends[dm1[IW-1:0]]);
  assign go         = q_valid && (!out_valid || !out_stall);
  assign b          = q_head.item.data_byte;
  assign pl_dec     = payload_left - 64'd1;

  // main decode and command logic
  always_comb begin
    phase_next        = phase;
    position_next     = position;
    id_acc_next       = id_acc;
    len_acc_next      = len_acc;
    fbl_next          = fbl;
    ones_next         = ones;
    len_size_next     = len_size;
    len_unk_next      = len_unk;
    payload_left_next = payload_left;
    rd_signed_next    = rd_signed;
    val_acc_next      = val_acc;
    pending_next      = pending;
    depth_next        = depth;
    q_pop             = 1'b0;
    has_res           = 1'b0;
    res               = '0;
    push_end          = 1'b0;
    push_val          = '0;
    n                 = lead_size(b);
    mask              = 8'h80 >> (n - 4'd1);
    done              = 1'b0;
    len_new           = len_acc;
    ones_new          = ones;
    size_new          = len_size;
    unk_new           = 1'b0;
    end_sum           = {1'b0, position} + {1'b0, len_acc};
    v                 = '0;
    if (go) begin
      if (q_head.cls.is_set_pos) begin
        q_pop             = 1'b1;
        phase_next        = PH_ID;
        position_next     = q_head.item.new_position;
        id_acc_next       = '0;
        len_acc_next      = '0;
        fbl_next          = '0;
        ones_next         = '0;
        len_size_next     = '0;
        len_unk_next      = 1'b0;
        payload_left_next = '0;
        rd_signed_next    = 1'b0;
        val_acc_next      = '0;
        pending_next      = '0;
        depth_next        = '0;
      end else if (phase == PH_ERR) begin
        q_pop = 1'b1;
      end else if (q_head.cls.is_end) begin
        q_pop = 1'b1;
        has_res = 1'b1;
        if ((phase == PH_ID && fbl == 4'd0) ||
            (phase == PH_CMD && payload_left == 64'd0 && !len_unk)) begin
          phase_next        = PH_ID;
          res.kind          = KIND_END;
          res.levels_closed = CLOSED_END;
        end else begin
          phase_next     = PH_ERR;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
        end
      end else if (q_head.cls.is_cmd) begin
        q_pop = 1'b1;
        if (phase == PH_CMD) begin
          if (q_head.item.action == ACT_ENTER) begin
            if (depth >= MAX_D) begin
              has_res        = 1'b1;
              phase_next     = PH_ERR;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_OVERFLOW;
            end else begin
              push_end   = 1'b1;
              push_val   = (len_unk || end_sum[64]) ? '1 : end_sum[63:0];
              depth_next = depth + 4'd1;
              phase_next = PH_ID;
            end
          end else if (len_unk) begin
            has_res        = 1'b1;
            phase_next     = PH_ERR;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_UNKNOWN;
          end else if (q_head.item.action == ACT_READ_U ||
                       q_head.item.action == ACT_READ_S) begin
            if (len_acc < 64'd1 || len_acc > 64'd8) begin
              has_res        = 1'b1;
              phase_next     = PH_ERR;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_INT_SIZE;
            end else begin
              val_acc_next   = '0;
              rd_signed_next = (q_head.item.action == ACT_READ_S);
              phase_next     = PH_INT;
            end
          end else if (payload_left == 64'd0) begin
            phase_next = PH_ID;
          end else begin
            phase_next = (q_head.item.action == ACT_SKIP) ? PH_SKIP : PH_RAW;
          end
        end
      end else begin
        // stream byte
        case (phase)
          PH_ID: begin
            if (fbl == 4'd0) begin
              if (n > 4'd4) begin
                q_pop          = 1'b1;
                has_res        = 1'b1;
                phase_next     = PH_ERR;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_ID_TAG;
              end else if (pop_hit) begin
                // close one nesting level per cycle while the output is not stalled, byte stays queued
                depth_next   = dm1;
                pending_next = (pending < CLOSED_SAT) ? pending + 4'd1 : pending;
              end else begin
                q_pop         = 1'b1;
                position_next = position + 64'd1;
                id_acc_next   = {24'd0, b};
                fbl_next      = n - 4'd1;
                if (n == 4'd1) phase_next = PH_LEN;
              end
            end else begin
              q_pop         = 1'b1;
              position_next = position + 64'd1;
              id_acc_next   = {id_acc[23:0], b};
              fbl_next      = fbl - 4'd1;
              if (fbl == 4'd1) phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            q_pop = 1'b1;
            if (len_size == 4'd0 && n > 4'd8) begin
              has_res        = 1'b1;
              phase_next     = PH_ERR;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_LEN_TAG;
            end else begin
              position_next = position + 64'd1;
              if (len_size == 4'd0) begin
                len_new  = {56'd0, b & (mask - 8'd1)};
                ones_new = (len_new[7:0] == (mask - 8'd1)) ? 4'd1 : 4'd0;
                size_new = n;
                fbl_next = n - 4'd1;
                done     = (n == 4'd1);
              end else begin
                len_new  = {len_acc[55:0], b};
                ones_new = (b == 8'hff) ? ones + 4'd1 : ones;
                size_new = len_size;
                fbl_next = fbl - 4'd1;
                done     = (fbl == 4'd1);
              end
              len_acc_next  = len_new;
              ones_next     = ones_new;
              len_size_next = size_new;
              if (done) begin
                unk_new           = (ones_new == size_new);
                len_unk_next      = unk_new;
                len_size_next     = 4'd0;
                payload_left_next = len_new;
                if (id_acc == void_id || id_acc == crc_id) begin
                  if (unk_new) begin
                    has_res        = 1'b1;
                    phase_next     = PH_ERR;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_UNKNOWN;
                  end else begin
                    phase_next = (len_new != 64'd0) ? PH_SKIP : PH_ID;
                  end
                end else begin
                  has_res            = 1'b1;
                  res.kind           = KIND_HEADER;
                  res.element_id     = id_acc;
                  res.data_length    = unk_new ? '1 : len_new;
                  res.length_unknown = unk_new;
                  res.levels_closed  = pending;
                  pending_next       = 4'd0;
                  phase_next         = PH_CMD;
                end
              end
            end
          end
          PH_SKIP: begin
            q_pop             = 1'b1;
            position_next     = position + 64'd1;
            payload_left_next = pl_dec;
            if (pl_dec == 64'd0) phase_next = PH_ID;
          end
          PH_INT: begin
            q_pop             = 1'b1;
            position_next     = position + 64'd1;
            val_acc_next      = {val_acc[55:0], b};
            payload_left_next = pl_dec;
            if (pl_dec == 64'd0) begin
              v = {val_acc[55:0], b};
              // sign extension from the top bit of the payload
              if (rd_signed) begin
                for (int k = 1; k < 8; k++) begin
                  if (len_acc[3:0] == 4'(k) && v[8*k-1]) v = v | ~((64'd1 << (8*k)) - 64'd1);
                end
              end
              has_res         = 1'b1;
              res.kind        = KIND_INT;
              res.element_id  = id_acc;
              res.data_length = len_unk ? '1 : len_acc;
              res.int_value   = v;
              phase_next      = PH_ID;
              rd_signed_next  = 1'b0;
            end
          end
          PH_RAW: begin
            q_pop             = 1'b1;
            position_next     = position + 64'd1;
            payload_left_next = pl_dec;
            has_res           = 1'b1;
            res.kind          = KIND_BYTE;
            res.element_id    = id_acc;
            res.data_length   = len_unk ? '1 : len_acc;
            res.payload_byte  = b;
            res.last_byte     = (pl_dec == 64'd0);
            if (pl_dec == 64'd0) phase_next = PH_ID;
          end
          default: begin
            // byte while a command is awaited is dropped
            q_pop = 1'b1;
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID;
      position     <= '0;
      id_acc       <= '0;
      len_acc      <= '0;
      fbl          <= '0;
      ones         <= '0;
      len_size     <= '0;
      len_unk      <= 1'b0;
      payload_left <= '0;
      rd_signed    <= 1'b0;
      val_acc      <= '0;
      pending      <= '0;
      depth        <= '0;
    end else begin
      phase        <= phase_next;
      position     <= position_next;
      id_acc       <= id_acc_next;
      len_acc      <= len_acc_next;
      fbl          <= fbl_next;
      ones         <= ones_next;
      len_size     <= len_size_next;
      len_unk      <= len_unk_next;
      payload_left <= payload_left_next;
      rd_signed    <= rd_signed_next;
      val_acc      <= val_acc_next;
      pending      <= pending_next;
      depth        <= depth_next;
    end
  end

  // nesting end offsets
  always_ff @(posedge clk) begin
    if (push_end) level_ends[depth[IW-1:0]] <= push_val;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      void_id <= VOID_ID_RESET;
      crc_id  <= CRC_ID_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_VOID_ID) void_id <= cfg_data;
      if (cfg_index == CFG_CRC_ID) crc_id <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (has_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (has_res) out_res <= res;
  end

endmodule
`default_nettype wire

FILE: hdl/ebml_element_stream_parser.sv
// ebml_element_stream_parser: top level, front queue plus parser back end
// depends on eesp_pkg, eesp_front, eesp_back
//
// channel  handshake             payload
// in       in_valid / in_stall   action, data_byte, new_position
// out      out_valid / out_stall kind .. error_code
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle through the two-entry queue and the parser while the output is not stalled
// the first id byte stays queued while nesting levels are closed (one end compare a cycle)
// a result waits in the output register; the parser holds while it is stalled
// rst is synchronous, clears the queue and parser state and resets the config registers to their defaults
`timescale 1ns / 1ps
`default_nettype none
module ebml_element_stream_parser #(
  parameter int MAX_NESTING = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         action,
  input  wire logic [7:0]         data_byte,
  input  wire logic [63:0]        new_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              kind,
  output logic [31:0]             element_id,
  output logic [63:0]             data_length,
  output logic                    length_unknown,
  output logic [3:0]              levels_closed,
  output logic signed [63:0]      int_value,
  output logic [7:0]              payload_byte,
  output logic                    last_byte,
  output logic [2:0]              error_code,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import eesp_pkg::*;

  item_t       in_item;
  logic        q_valid;
  qent_t       q_head;
  logic        q_pop;
  front_stat_t fstat;
  back_stat_t  bstat;
  result_t     res;

  assign cfg_ready            = 1'b1;
  assign in_item.action       = action_t'(action);
  assign in_item.data_byte    = data_byte;
  assign in_item.new_position = new_position;

  eesp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .stat     (fstat)
  );

  eesp_back #(
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .stat      (bstat)
  );

  assign kind           = res.kind;
  assign element_id     = res.element_id;
  assign data_length    = res.data_length;
  assign length_unknown = res.length_unknown;
  assign levels_closed  = res.levels_closed;
  assign int_value      = res.int_value;
  assign payload_byte   = res.payload_byte;
  assign last_byte      = res.last_byte;
  assign error_code     = res.error_code;

  // error results carry a code, others none
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE)
    else $error("error result without code");

  a_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
    else $error("code on non-error result");

  // nesting never exceeds the stack
  a_depth: assert property (@(posedge clk) disable iff (rst)
    bstat.depth <= 4'(MAX_NESTING))
    else $error("nesting depth overflow");

  // queue never pops empty
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fstat.count != 2'd0)
    else $error("queue underflow");

endmodule
`default_nettype wire
